### rtl/core/pop3rd_pkg.sv
// Package for the POP3 response deframer: beat types, state codes,
// outcome codes and sizing constants. No dependencies.
package pop3rd_pkg;

    // Longest line accepted before the response is aborted
    localparam int MAX_LINE = 512;
    localparam int LEN_W    = $clog2(MAX_LINE + 1);

    // Result queue depth; one input beat may add up to three results
    localparam int QDEPTH   = 6;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int MAX_RES  = 3;

    // Input beat kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // Phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    // +OK prefix match progress; PFX_BAD marks a mismatch
    localparam logic [2:0] PFX_DONE = 3'd3;
    localparam logic [2:0] PFX_BAD  = 3'd4;

    // Held leading bytes of a body line
    localparam logic [1:0] HOLD_NONE   = 2'd0;
    localparam logic [1:0] HOLD_DOT    = 2'd1;
    localparam logic [1:0] HOLD_DOT_CR = 2'd2;

    // Outcome codes
    localparam logic [2:0] OC_PROGRESS = 3'd0;
    localparam logic [2:0] OC_OK       = 3'd1;
    localparam logic [2:0] OC_ERROR    = 3'd2;
    localparam logic [2:0] OC_OVERFLOW = 3'd3;
    localparam logic [2:0] OC_TIMEOUT  = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       expect_multiline;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        logic [2:0] outcome;
    } res_item_t;

    // Results caused by one input beat, in delivery order from index 0
    typedef struct packed {
        logic [1:0]                count;
        res_item_t [MAX_RES-1:0]   res;
    } step_out_t;

    // Expected character of "+OK" at a given match position
    function automatic logic [7:0] ok_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = 8'h2B;
            2'd1:    c = 8'h4F;
            2'd2:    c = 8'h4B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic res_item_t data_res(input logic [7:0] b);
        res_item_t r;
        r.out_byte = b;
        r.has_byte = 1'b1;
        r.last     = 1'b0;
        r.outcome  = OC_PROGRESS;
        return r;
    endfunction

    function automatic res_item_t end_res(input logic [2:0] oc);
        res_item_t r;
        r.out_byte = 8'h00;
        r.has_byte = 1'b0;
        r.last     = 1'b1;
        r.outcome  = oc;
        return r;
    endfunction

endpackage

### rtl/core/pop3rd_step.sv
// Per-beat deframing logic: response state registers and the results that
// one accepted beat causes. Depends on pop3rd_pkg.
module pop3rd_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  pop3rd_pkg::in_item_t item,
    output pop3rd_pkg::step_out_t step
);
    import pop3rd_pkg::*;

    logic [1:0]       phase_reg,  phase_next;
    logic [2:0]       pfx_reg,    pfx_next;
    logic [LEN_W-1:0] len_reg,    len_next;
    logic [1:0]       held_reg,   held_next;
    logic             mode_reg,   mode_next;

    logic             idle;
    logic [2:0]       pfx_cur;
    logic [1:0]       held_cur;
    logic             mode_cur;
    logic [LEN_W-1:0] len_inc;
    logic             lf;
    logic [7:0]       b;

    // Effective state: an idle block starts a fresh response
    always_comb
    begin
        b        = item.data_byte;
        lf       = (b == CH_LF);
        idle     = (phase_reg == PH_IDLE);
        pfx_cur  = idle ? 3'd0 : pfx_reg;
        held_cur = idle ? HOLD_NONE : held_reg;
        mode_cur = idle ? item.expect_multiline : mode_reg;
        len_inc  = (idle ? '0 : len_reg) + LEN_W'(1);
    end

    // Next state and results for the beat
    always_comb
    begin
        phase_next = phase_reg;
        pfx_next   = pfx_reg;
        len_next   = len_reg;
        held_next  = held_reg;
        mode_next  = mode_reg;
        step.count = 2'd0;
        step.res   = '0;

        priority if (item.kind == KIND_TIMEOUT)
        begin
            phase_next  = PH_IDLE;
            pfx_next    = 3'd0;
            len_next    = '0;
            held_next   = HOLD_NONE;
            step.count  = 2'd1;
            step.res[0] = end_res(OC_TIMEOUT);
        end
        else if (len_inc >= LEN_W'(MAX_LINE) && !lf)
        begin
            mode_next   = mode_cur;
            phase_next  = PH_IDLE;
            pfx_next    = 3'd0;
            len_next    = '0;
            held_next   = HOLD_NONE;
            step.count  = 2'd1;
            step.res[0] = end_res(OC_OVERFLOW);
        end
        else if (idle || phase_reg == PH_FIRST)
        begin
            // First line: pass through while matching +OK
            mode_next   = mode_cur;
            step.count  = 2'd1;
            step.res[0] = data_res(b);
            if (pfx_cur < PFX_DONE)
            begin
                pfx_next = (b == ok_char(pfx_cur[1:0])) ? pfx_cur + 3'd1 : PFX_BAD;
            end
            else
            begin
                pfx_next = pfx_cur;
            end
            priority if (!lf)
            begin
                phase_next = PH_FIRST;
                len_next   = len_inc;
                held_next  = HOLD_NONE;
            end
            else if (pfx_next == PFX_DONE && mode_cur)
            begin
                phase_next = PH_BODY;
                len_next   = '0;
                held_next  = HOLD_NONE;
            end
            else
            begin
                step.res[0].last    = 1'b1;
                step.res[0].outcome = (pfx_next == PFX_DONE) ? OC_OK : OC_ERROR;
                phase_next = PH_IDLE;
                pfx_next   = 3'd0;
                len_next   = '0;
                held_next  = HOLD_NONE;
            end
        end
        else
        begin
            // Body line: dot unstuffing and end marker
            len_next  = lf ? '0 : len_inc;
            held_next = HOLD_NONE;
            priority if (held_cur == HOLD_DOT)
            begin
                priority if (b == CH_DOT)
                begin
                    step.count  = 2'd1;
                    step.res[0] = data_res(CH_DOT);
                end
                else if (b == CH_CR)
                begin
                    held_next = HOLD_DOT_CR;
                end
                else
                begin
                    step.count  = 2'd2;
                    step.res[0] = data_res(CH_DOT);
                    step.res[1] = data_res(b);
                end
            end
            else if (held_cur == HOLD_DOT_CR)
            begin
                if (lf)
                begin
                    phase_next  = PH_IDLE;
                    pfx_next    = 3'd0;
                    len_next    = '0;
                    step.count  = 2'd1;
                    step.res[0] = end_res(OC_OK);
                end
                else
                begin
                    step.count  = 2'd3;
                    step.res[0] = data_res(CH_DOT);
                    step.res[1] = data_res(CH_CR);
                    step.res[2] = data_res(b);
                end
            end
            else if (len_inc == LEN_W'(1) && b == CH_DOT)
            begin
                held_next = HOLD_DOT;
            end
            else
            begin
                step.count  = 2'd1;
                step.res[0] = data_res(b);
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pfx_reg   <= 3'd0;
            len_reg   <= '0;
            held_reg  <= HOLD_NONE;
            mode_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pfx_reg   <= pfx_next;
            len_reg   <= len_next;
            held_reg  <= held_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

### rtl/core/pop3_response_deframer_top.sv
// Top level of the POP3 response deframer: input channel, step logic and
// result queue. Depends on pop3rd_pkg and pop3rd_step.
//
// Usage:
//   byte channel (byte_valid / byte_stall / byte_item) carries one received
//   byte or a read-timeout event per beat. res channel (res_valid /
//   res_stall / res_item) carries one result per beat: an unstuffed byte,
//   and on the beat that ends a response, last with its outcome.
//   Each input beat causes zero to three results. They are computed in the
//   cycle the beat is accepted and written to a six-entry result queue whose
//   head is the registered output. Throughput is one input beat per cycle
//   while the receiver keeps up; byte_stall rises whenever the queue has
//   fewer than three free entries, which is set by the worst-case burst of a
//   held dot and CR followed by another byte.
//   A stalled result beat holds its value; the queue keeps absorbing input
//   beats until fewer than three of its entries are free.
//   Reset empties the queue and returns the deframer to waiting for the
//   start of a response.
module pop3_response_deframer_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  pop3rd_pkg::in_item_t  byte_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output pop3rd_pkg::res_item_t res_item
);
    import pop3rd_pkg::*;

    logic                    fire;
    logic                    pop;
    step_out_t               step;
    res_item_t [QDEPTH-1:0]  q_reg,   q_next;
    logic [QCNT_W-1:0]       cnt_reg, cnt_next;
    logic [QCNT_W-1:0]       base;
    logic [QCNT_W-1:0]       push_n;
    logic [QCNT_W-1:0]       off;

    // Handshakes
    assign byte_stall = (cnt_reg > QCNT_W'(QDEPTH - MAX_RES));
    assign fire       = byte_valid && !byte_stall;
    assign res_valid  = (cnt_reg != '0);
    assign res_item   = q_reg[0];
    assign pop        = res_valid && !res_stall;

    pop3rd_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (byte_item),
        .step  (step)
    );

    // Queue update: shift out the head, append new results behind the rest
    always_comb
    begin
        base     = cnt_reg - QCNT_W'(pop);
        push_n   = fire ? QCNT_W'(step.count) : '0;
        cnt_next = base + push_n;
        for (int i = 0; i < QDEPTH; i++)
        begin
            off = QCNT_W'(i) - base;
            if (pop && i < QDEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (QCNT_W'(i) >= base && off < push_n)
            begin
                q_next[i] = step.res[off[1:0]];
            end
        end
    end

    // Queue occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

### rtl/core/pop3rd_checker.sv
// Port-level checks for the POP3 response deframer, bound to the top level.
// Depends on pop3rd_pkg and pop3_response_deframer_top.
module pop3rd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_stall,
    input pop3rd_pkg::res_item_t res_item
);
    import pop3rd_pkg::*;

    // A stalled result beat stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result beat changed while stalled");

    // A result without a byte always closes the response
    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.has_byte |-> res_item.last && res_item.out_byte == 8'h00)
        else $error("byteless result does not end the response");

    // Only the closing result carries an outcome
    a_outcome_mid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.last |-> res_item.outcome == OC_PROGRESS)
        else $error("outcome set on a result inside a response");

    // The closing result always carries a final outcome
    a_outcome_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.last |-> res_item.outcome != OC_PROGRESS)
        else $error("closing result without an outcome");

endmodule

bind pop3_response_deframer_top pop3rd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pop3_response_deframer_top: drives received bytes and timeouts,
// predicts the unstuffed result stream and checks every result beat.
// Depends on pop3rd_pkg and the deframer RTL.
module tb;
    import pop3rd_pkg::*;

    localparam int          RANDOM_BEATS   = 460;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam logic [23:0] OK_WORD        = "+OK";

    // Predicts the result beats of the deframer and holds those still to arrive
    class deframe_scoreboard;
        res_item_t        pending_res[$];
        int               errors;
        logic [1:0]       phase;
        logic [2:0]       pfx;
        logic [LEN_W-1:0] line_len;
        logic [1:0]       held;
        logic             ml_mode;

        function new();
            errors  = 0;
            ml_mode = 1'b0;
            go_idle();
        endfunction

        function void go_idle();
            phase    = PH_IDLE;
            pfx      = 3'd0;
            line_len = '0;
            held     = HOLD_NONE;
        endfunction

        function void want(logic [7:0] b, logic has, logic last_flag, logic [2:0] oc);
            res_item_t r;
            r.out_byte = has ? b : 8'h00;
            r.has_byte = has;
            r.last     = last_flag;
            r.outcome  = oc;
            pending_res.push_back(r);
        endfunction

        function void want_data(logic [7:0] b);
            want(b, 1'b1, 1'b0, OC_PROGRESS);
        endfunction

        function void want_end(logic [2:0] oc);
            want(8'h00, 1'b0, 1'b1, oc);
        endfunction

        // Work out the results of one accepted input beat
        function void note_beat(in_item_t it);
            logic [7:0] b;
            logic       is_lf;
            b     = it.data_byte;
            is_lf = (b == CH_LF);
            if (it.kind == KIND_TIMEOUT)
            begin
                go_idle();
                want_end(OC_TIMEOUT);
                return;
            end
            if (phase == PH_IDLE)
            begin
                go_idle();
                phase   = PH_FIRST;
                ml_mode = it.expect_multiline;
            end
            line_len = line_len + 1'b1;
            if (line_len >= MAX_LINE && !is_lf)
            begin
                go_idle();
                want_end(OC_OVERFLOW);
                return;
            end

            // first line: pass through, track the +OK prefix
            if (phase == PH_FIRST)
            begin
                if (pfx < PFX_DONE)
                    pfx = (b == OK_WORD[8*(2-int'(pfx)) +: 8]) ? pfx + 3'd1 : PFX_BAD;
                if (!is_lf)
                begin
                    want_data(b);
                    return;
                end
                if (pfx == PFX_DONE && ml_mode)
                begin
                    phase    = PH_BODY;
                    line_len = '0;
                    held     = HOLD_NONE;
                    want_data(b);
                    return;
                end
                want(b, 1'b1, 1'b1, (pfx == PFX_DONE) ? OC_OK : OC_ERROR);
                go_idle();
                return;
            end

            // body: resolve a held leading dot, or start holding one
            case (held)
                HOLD_DOT:
                begin
                    held = HOLD_NONE;
                    if (b == CH_DOT)
                    begin
                        want_data(CH_DOT);
                        return;
                    end
                    if (b == CH_CR)
                    begin
                        held = HOLD_DOT_CR;
                        return;
                    end
                    want_data(CH_DOT);
                end
                HOLD_DOT_CR:
                begin
                    held = HOLD_NONE;
                    if (is_lf)
                    begin
                        go_idle();
                        want_end(OC_OK);
                        return;
                    end
                    want_data(CH_DOT);
                    want_data(CH_CR);
                end
                default:
                begin
                    if (line_len == 1 && b == CH_DOT)
                    begin
                        held = HOLD_DOT;
                        return;
                    end
                end
            endcase
            want_data(b);
            if (is_lf)
                line_len = '0;
        endfunction

        function void compare_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
            if (exp_v !== got_v)
            begin
                $error("%s: expected %0h, got %0h", field, exp_v, got_v);
                errors++;
            end
        endfunction

        // Compare an accepted result beat with the oldest prediction
        function void check_result(res_item_t got);
            res_item_t exp_r;
            if (pending_res.size() == 0)
            begin
                $error({"result beat with none outstanding: ",
                        "out_byte %0h has_byte %0b last %0b outcome %0d"},
                       got.out_byte, got.has_byte, got.last, got.outcome);
                errors++;
                return;
            end
            exp_r = pending_res.pop_front();
            compare_field("out_byte", exp_r.out_byte, got.out_byte);
            compare_field("has_byte", 8'(exp_r.has_byte), 8'(got.has_byte));
            compare_field("last", 8'(exp_r.last), 8'(got.last));
            compare_field("outcome", 8'(exp_r.outcome), 8'(got.outcome));
        endfunction

        function int outstanding();
            return pending_res.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    deframe_scoreboard sb = new();
    int  beats_sent   = 0;
    int  quiet_cycles = 0;
    int  tx_run       = 0;
    int  rx_run       = 0;
    bit  rx_hold_due  = 1'b0;

    pop3_response_deframer_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle cycles before a beat; occasional runs with no idling at all
    function automatic int draw_gap(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Random line content; never a line feed so lines stay whole
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = CH_DOT;
            1:       b = CH_CR;
            2, 3:    b = 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        if (b == CH_LF)
            b = 8'h4C;
        return b;
    endfunction

    // Offer one beat and wait for it to be taken
    task automatic send_beat(input logic kind, input logic [7:0] b, input logic ml);
        int gap;
        gap = draw_gap(tx_run);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid                <= 1'b1;
        byte_item.kind             <= kind;
        byte_item.data_byte        <= b;
        byte_item.expect_multiline <= ml;
        do @(posedge clk); while (!(byte_valid && !byte_stall));
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(KIND_BYTE, b, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_timeout();
        send_beat(KIND_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // ml only matters on the first byte of a response
    task automatic send_text(input string s, input logic ml);
        for (int i = 0; i < s.len(); i++)
        begin
            if (i == 0)
                send_beat(KIND_BYTE, s[i], ml);
            else
                send_byte(s[i]);
        end
    endtask

    task automatic send_random_text(input int n);
        repeat (n) send_byte(text_byte());
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_line_end();
        if ($urandom_range(0, 3) == 0)
            send_byte(CH_LF);
        else
            send_crlf();
    endtask

    // One body line: plain, stuffed dot, dot followed by text, or dot CR with more after it
    task automatic body_line();
        int min_len;
        min_len = 0;
        case ($urandom_range(0, 5))
            0: send_text("..", 1'($urandom_range(0, 1)));
            1:
            begin
                send_byte(CH_DOT);
                min_len = 1;
            end
            2:
            begin
                send_byte(CH_DOT);
                send_byte(CH_CR);
                min_len = 1;
            end
            default: ;
        endcase
        send_random_text($urandom_range(min_len, 10));
        send_line_end();
    endtask

    task automatic random_response();
        int shape;
        int n;
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1, 2, 3, 4:
            begin
                // multiline response, ended by dot CR LF or a timeout
                send_text("+OK", 1'b1);
                send_random_text($urandom_range(0, 6));
                send_line_end();
                n = $urandom_range(0, 5);
                repeat (n) body_line();
                if ($urandom_range(0, 7) == 0)
                    send_timeout();
                else
                begin
                    send_byte(CH_DOT);
                    send_crlf();
                end
            end
            5, 6:
            begin
                send_text("+OK", 1'b0);
                send_random_text($urandom_range(0, 8));
                send_line_end();
            end
            7:
            begin
                send_text("-ERR", 1'($urandom_range(0, 1)));
                send_random_text($urandom_range(0, 8));
                send_line_end();
            end
            8:
            begin
                // short or garbled first line
                send_beat(KIND_BYTE, text_byte(), 1'($urandom_range(0, 1)));
                send_random_text($urandom_range(0, 4));
                send_byte(CH_LF);
            end
            default:
            begin
                // noise with stray line feeds, cut off by a timeout
                n = $urandom_range(1, 12);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                send_timeout();
            end
        endcase
    endtask

    // Lines at and over the length limit, in the first line and in the body
    task automatic long_lines();
        send_text("+OK", 1'($urandom_range(0, 1)));
        send_random_text(MAX_LINE - 3);
        send_text("+OK", 1'b1);
        send_byte(CH_LF);
        send_byte(8'h41);
        send_random_text(MAX_LINE - 2);
        send_byte(CH_LF);
        send_byte(8'h42);
        send_random_text(MAX_LINE - 1);
        send_text("+OK", 1'b0);
        send_crlf();
    endtask

    // Receiver: random stall before each beat, plus one long hold-off
    initial
    begin : result_sink
        int gap;
        res_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_due)
            begin
                rx_hold_due = 1'b0;
                res_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            gap = draw_gap(rx_run);
            if (gap > 0)
            begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!(res_valid && !res_stall));
        end
    end

    // Beat monitor and watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                sb.note_beat(byte_item);
            if (res_valid && !res_stall)
                sb.check_result(res_item);
            if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int first_random;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: timeout while idle
        send_beat(KIND_TIMEOUT, 8'hFF, 1'b1);
        // single-line OK reply
        send_text("+OK", 1'b0);
        send_crlf();
        // first line shorter than +OK
        send_text("+", 1'b1);
        send_byte(CH_LF);
        // multiline: stuffed dot, unstuffed dot with extreme bytes, dot CR then text
        send_text("+OK", 1'b1);
        send_byte(CH_LF);
        send_text("..", 1'b0);
        send_byte(CH_LF);
        send_byte(CH_DOT);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_LF);
        send_byte(CH_DOT);
        send_byte(CH_CR);
        send_byte(8'h5A);
        send_byte(CH_LF);
        // terminating dot line
        send_byte(CH_DOT);
        send_crlf();

        // random responses, with one long receiver hold-off near the start
        rx_hold_due  = 1'b1;
        first_random = beats_sent;
        while (beats_sent < first_random + RANDOM_BEATS)
            random_response();
        long_lines();
        byte_valid <= 1'b0;

        // wait for the monitor to record the last beat
        @(posedge clk);
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
